// ===== hdl/lzrd_pkg.sv =====
// Package for the LZRW1 run-length decompressor.
// Holds the parser phase type, the engine state type and fixed widths; depends on nothing.
package lzrd_pkg;
  localparam int BYTE_W = 8;
  localparam int REP_W  = 13;

  typedef enum logic [2:0] {
    PH_HEAD0, PH_HEAD1, PH_HEAD2, PH_ITEM, PH_CTRL_LO, PH_PAIR_B1, PH_RUN_B2, PH_RUN_B3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COPY_RD, ST_COPY_WAIT, ST_COPY_OUT, ST_RUN_FILL, ST_OUT
  } eng_t;
endpackage

// ===== hdl/lzrd_if.sv =====
// Valid/ready stream interfaces for the decompressor.
// Depends on lzrd_pkg for widths.
interface lzrd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lzrd_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface lzrd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lzrd_pkg::BYTE_W-1:0] out_byte;
  logic [lzrd_pkg::REP_W-1:0]  repeat_count;
  logic                       distance_error;
  logic                       last_of_run;
  modport source (output valid, out_byte, repeat_count, distance_error, last_of_run,
                  input ready);
  modport sink   (input valid, out_byte, repeat_count, distance_error, last_of_run,
                  output ready);
endinterface

interface lzrd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lzrd_pkg::BYTE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/lzrd_hist_ram.sv =====
// History window memory: one write port, one registered read port.
// Depends on lzrd_pkg for the byte width.
module lzrd_hist_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lzrd_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [lzrd_pkg::BYTE_W-1:0] rdata
);
  logic [lzrd_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lzrw1_rle_decompressor.sv =====
// Top level of the LZRW1 run-length decompressor: parser, copy engine
// and result register. Depends on lzrd_pkg, the interfaces and lzrd_hist_ram.
//
// A user should know: one compressed word is taken at a time. Header,
// control and literal words are handled as they are taken; a literal's result
// then waits in the output register. A match copy of length L (3..18) goes
// through a read, a wait and an output state for each byte, set by the
// registered read port of the history memory and the read-after-write
// dependency of overlapping copies. A run item fills the history with its
// value, one entry per cycle; its single result goes out as soon as the fill
// ends. There is no clearing pass: the distance check keeps data from
// unwritten history entries out of the results.
module lzrw1_rle_decompressor #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic clk,
  input  logic rst_n,
  lzrd_in_if.sink    in_ch,
  lzrd_out_if.source out_ch,
  lzrd_cfg_if.sink   cfg_ch
);
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int PW = AW + 1;

  logic [7:0] copied_flag_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) copied_flag_r <= 8'd1;
    else if (cfg_ch.valid) copied_flag_r <= cfg_ch.data;
  end

  lzrd_pkg::phase_t phase_r, phase_nxt;
  lzrd_pkg::eng_t   st_r, st_nxt;
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [15:0]    cw_r, cw_nxt;
  logic [4:0]     bits_r, bits_nxt;
  logic [7:0]     h1_r, h1_nxt, h2_r, h2_nxt;
  logic           pt_r, pt_nxt;
  logic           last_r, last_nxt;   // in_last of the word being worked on
  logic [AW-1:0]  dist_r, dist_nxt;
  logic [4:0]     len_r, len_nxt;     // copy bytes left, or unused
  logic [12:0]    cnt_r, cnt_nxt;     // run fill entries left
  logic           err_r, err_nxt;

  logic           ov_r, ov_nxt;
  logic [7:0]     ob_r, ob_nxt;
  logic [12:0]    orep_r, orep_nxt;
  logic           oerr_r, oerr_nxt;
  logic           olast_r, olast_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata, rdata;

  lzrd_hist_ram #(.DEPTH(WINDOW_DEPTH)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic out_free;
  assign out_free     = !ov_r || out_ch.ready;
  assign in_ch.ready  = (st_r == lzrd_pkg::ST_IDLE) && out_free;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = ov_r;
  assign out_ch.out_byte       = ob_r;
  assign out_ch.repeat_count   = orep_r;
  assign out_ch.distance_error = oerr_r;
  assign out_ch.last_of_run    = olast_r;

  assign raddr = wp_r - dist_r;

  // Saturating add to the produced count.
  function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a, input logic [12:0] n);
    logic [13:0] s;
    s = 14'(a) + 14'(n);
    sat_add = (s > 14'(WINDOW_DEPTH)) ? PW'(WINDOW_DEPTH) : PW'(s);
  endfunction

  // Stream state cleared at the end of a stream.
  logic clr;

  always_comb begin
    phase_nxt = phase_r; st_nxt = st_r; wp_nxt = wp_r; prod_nxt = prod_r;
    cw_nxt = cw_r; bits_nxt = bits_r; h1_nxt = h1_r; h2_nxt = h2_r; pt_nxt = pt_r;
    last_nxt = last_r; dist_nxt = dist_r; len_nxt = len_r; cnt_nxt = cnt_r;
    err_nxt = err_r;
    ov_nxt = ov_r && !out_ch.ready; ob_nxt = ob_r; orep_nxt = orep_r;
    oerr_nxt = oerr_r; olast_nxt = olast_r;
    we = 1'b0; waddr = wp_r; wdata = 8'd0; clr = 1'b0;

    unique case (st_r)
      lzrd_pkg::ST_IDLE: begin
        if (acc) begin
          last_nxt = in_ch.in_last;
          clr = in_ch.in_last;
          if (pt_r) begin
            ov_nxt = 1'b1; ob_nxt = in_ch.in_byte; orep_nxt = 13'd1;
            oerr_nxt = 1'b0; olast_nxt = 1'b1;
          end else begin
            unique case (phase_r)
              lzrd_pkg::PH_HEAD0: begin
                if (in_ch.in_byte == copied_flag_r) pt_nxt = 1'b1;
                else phase_nxt = lzrd_pkg::PH_HEAD1;
              end
              lzrd_pkg::PH_HEAD1: begin
                h1_nxt = in_ch.in_byte; phase_nxt = lzrd_pkg::PH_HEAD2;
              end
              lzrd_pkg::PH_HEAD2, lzrd_pkg::PH_CTRL_LO: begin
                cw_nxt = {h1_r, in_ch.in_byte}; bits_nxt = 5'd16;
                phase_nxt = lzrd_pkg::PH_ITEM;
              end
              lzrd_pkg::PH_ITEM: begin
                if (bits_r == 5'd0) begin
                  h1_nxt = in_ch.in_byte; phase_nxt = lzrd_pkg::PH_CTRL_LO;
                end else if (cw_r[15]) begin
                  h1_nxt = in_ch.in_byte; phase_nxt = lzrd_pkg::PH_PAIR_B1;
                end else begin
                  ov_nxt = 1'b1; ob_nxt = in_ch.in_byte; orep_nxt = 13'd1;
                  oerr_nxt = 1'b0; olast_nxt = 1'b1;
                  we = 1'b1; wdata = in_ch.in_byte;
                  wp_nxt = wp_r + 1'b1; prod_nxt = sat_add(prod_r, 13'd1);
                  cw_nxt = {cw_r[14:0], 1'b0}; bits_nxt = bits_r - 1'b1;
                end
              end
              lzrd_pkg::PH_PAIR_B1: begin
                dist_nxt = AW'({h1_r, in_ch.in_byte[7:4]});
                if ({h1_r, in_ch.in_byte[7:4]} != 12'd0) begin
                  len_nxt = {1'b0, in_ch.in_byte[3:0]} + 5'd3;
                  err_nxt = PW'({h1_r, in_ch.in_byte[7:4]}) > prod_r;
                  cw_nxt = {cw_r[14:0], 1'b0}; bits_nxt = bits_r - 1'b1;
                  phase_nxt = lzrd_pkg::PH_ITEM;
                  st_nxt = lzrd_pkg::ST_COPY_RD;
                  clr = 1'b0;
                end else begin
                  h2_nxt = in_ch.in_byte; phase_nxt = lzrd_pkg::PH_RUN_B2;
                end
              end
              lzrd_pkg::PH_RUN_B2: begin
                h1_nxt = in_ch.in_byte; phase_nxt = lzrd_pkg::PH_RUN_B3;
              end
              lzrd_pkg::PH_RUN_B3: begin
                ob_nxt = in_ch.in_byte;
                orep_nxt = 13'({h2_r[3:0], h1_r}) + 13'd16;
                cnt_nxt = 13'({h2_r[3:0], h1_r}) + 13'd16;
                cw_nxt = {cw_r[14:0], 1'b0}; bits_nxt = bits_r - 1'b1;
                phase_nxt = lzrd_pkg::PH_ITEM;
                st_nxt = lzrd_pkg::ST_RUN_FILL;
                clr = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
      lzrd_pkg::ST_COPY_RD:   st_nxt = lzrd_pkg::ST_COPY_WAIT;  // address presented
      lzrd_pkg::ST_COPY_WAIT: st_nxt = lzrd_pkg::ST_COPY_OUT;   // read data registered
      lzrd_pkg::ST_COPY_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; ob_nxt = err_r ? 8'd0 : rdata; orep_nxt = 13'd1;
          oerr_nxt = err_r; olast_nxt = (len_r == 5'd1);
          we = 1'b1; wdata = err_r ? 8'd0 : rdata;
          wp_nxt = wp_r + 1'b1; prod_nxt = sat_add(prod_r, 13'd1);
          len_nxt = len_r - 1'b1;
          if (len_r == 5'd1) begin
            st_nxt = lzrd_pkg::ST_IDLE; clr = last_r;
          end else st_nxt = lzrd_pkg::ST_COPY_RD;
        end
      end
      lzrd_pkg::ST_RUN_FILL: begin
        we = 1'b1; wdata = ob_r;
        wp_nxt = wp_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 13'd1) begin
          prod_nxt = sat_add(prod_r, orep_r);
          st_nxt = lzrd_pkg::ST_OUT;
        end
      end
      lzrd_pkg::ST_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; oerr_nxt = 1'b0; olast_nxt = 1'b1;
          st_nxt = lzrd_pkg::ST_IDLE; clr = last_r;
        end
      end
      default: st_nxt = lzrd_pkg::ST_IDLE;
    endcase

    if (clr) begin
      wp_nxt = '0; prod_nxt = '0; cw_nxt = '0; bits_nxt = '0;
      phase_nxt = lzrd_pkg::PH_HEAD0; h1_nxt = '0; h2_nxt = '0; pt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lzrd_pkg::PH_HEAD0; st_r <= lzrd_pkg::ST_IDLE;
      wp_r <= '0; prod_r <= '0; cw_r <= '0; bits_r <= '0;
      h1_r <= '0; h2_r <= '0; pt_r <= 1'b0; ov_r <= 1'b0; last_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; st_r <= st_nxt;
      wp_r <= wp_nxt; prod_r <= prod_nxt; cw_r <= cw_nxt; bits_r <= bits_nxt;
      h1_r <= h1_nxt; h2_r <= h2_nxt; pt_r <= pt_nxt; ov_r <= ov_nxt; last_r <= last_nxt;
    end
    dist_r <= dist_nxt; len_r <= len_nxt; cnt_r <= cnt_nxt; err_r <= err_nxt;
    ob_r <= ob_nxt; orep_r <= orep_nxt; oerr_r <= oerr_nxt; olast_r <= olast_nxt;
  end
endmodule

// ===== tb/lzrd_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the stream interfaces live in hdl/lzrd_if.sv and are reused as is.
// This file holds the word type shared by the testbench; depends on lzrd_pkg.
package lzrd_tb_pkg;
  typedef struct packed {
    logic [lzrd_pkg::BYTE_W-1:0] data;
    logic [lzrd_pkg::REP_W-1:0]  rep;
    logic                        err;
    logic                        last;
  } result_word_t;
endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lzrw1_rle_decompressor.
// Depends on lzrd_pkg, the stream interfaces and lzrd_tb_pkg.
module testbench;
  localparam int WIN = 4096;
  localparam int WATCHDOG_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  lzrd_in_if  in_ch ();
  lzrd_out_if out_ch ();
  lzrd_cfg_if cfg_ch ();

  lzrw1_rle_decompressor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // The predictor keeps its own copy of the decompressor state.
  logic [7:0]        win_mem [WIN];
  logic [11:0]       wr_ptr;
  int                made_cnt;
  logic [15:0]       ctl_word;
  int                ctl_bits;
  lzrd_pkg::phase_t  phase;
  logic [7:0]        hold_a, hold_b;
  logic              raw_mode;
  logic [7:0]        raw_flag;

  lzrd_tb_pkg::result_word_t expected_words[$];
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  function automatic void clear_stream_state();
    wr_ptr = '0;
    made_cnt = 0;
    ctl_word = '0;
    ctl_bits = 0;
    phase = lzrd_pkg::PH_HEAD0;
    hold_a = '0;
    hold_b = '0;
    raw_mode = 1'b0;
  endfunction

  function automatic void record_byte(logic [7:0] v, int cnt);
    for (int k = 0; k < cnt; k++) begin
      win_mem[wr_ptr] = v;
      wr_ptr = wr_ptr + 12'd1;
    end
    made_cnt = (made_cnt + cnt > WIN) ? WIN : made_cnt + cnt;
  endfunction

  function automatic void take_ctl_bit();
    ctl_word = ctl_word << 1;
    if (ctl_bits > 0) ctl_bits--;
  endfunction

  // Works out the results that one compressed word causes and queues them.
  function automatic void predict_decode(logic [7:0] b, logic last);
    lzrd_tb_pkg::result_word_t got[$];
    lzrd_tb_pkg::result_word_t w;
    logic [11:0] back_dist;
    int len;
    logic bad;
    logic [7:0] v;
    if (raw_mode) begin
      w = '{data: b, rep: 13'd1, err: 1'b0, last: 1'b0};
      got.push_back(w);
    end else begin
      case (phase)
        lzrd_pkg::PH_HEAD0: begin
          if (b == raw_flag) raw_mode = 1'b1;
          else phase = lzrd_pkg::PH_HEAD1;
        end
        lzrd_pkg::PH_HEAD1: begin
          hold_a = b;
          phase = lzrd_pkg::PH_HEAD2;
        end
        lzrd_pkg::PH_HEAD2, lzrd_pkg::PH_CTRL_LO: begin
          ctl_word = {hold_a, b};
          ctl_bits = 16;
          phase = lzrd_pkg::PH_ITEM;
        end
        lzrd_pkg::PH_ITEM: begin
          if (ctl_bits == 0) begin
            hold_a = b;
            phase = lzrd_pkg::PH_CTRL_LO;
          end else if (ctl_word[15]) begin
            hold_a = b;
            phase = lzrd_pkg::PH_PAIR_B1;
          end else begin
            w = '{data: b, rep: 13'd1, err: 1'b0, last: 1'b0};
            got.push_back(w);
            record_byte(b, 1);
            take_ctl_bit();
          end
        end
        lzrd_pkg::PH_PAIR_B1: begin
          back_dist = {hold_a, b[7:4]};
          if (back_dist != 0) begin
            len = b[3:0] + 3;
            bad = (back_dist > made_cnt);
            for (int k = 0; k < len; k++) begin
              v = bad ? 8'h00 : win_mem[wr_ptr - back_dist];
              w = '{data: v, rep: 13'd1, err: bad, last: 1'b0};
              got.push_back(w);
              record_byte(v, 1);
            end
            take_ctl_bit();
            phase = lzrd_pkg::PH_ITEM;
          end else begin
            hold_b = b;
            phase = lzrd_pkg::PH_RUN_B2;
          end
        end
        lzrd_pkg::PH_RUN_B2: begin
          hold_a = b;
          phase = lzrd_pkg::PH_RUN_B3;
        end
        default: begin
          len = {hold_b[3:0], hold_a} + 16;
          w = '{data: b, rep: 13'(len), err: 1'b0, last: 1'b0};
          got.push_back(w);
          record_byte(b, len);
          take_ctl_bit();
          phase = lzrd_pkg::PH_ITEM;
        end
      endcase
    end
    if (got.size() > 0) got[got.size() - 1].last = 1'b1;
    foreach (got[i]) expected_words.push_back(got[i]);
    if (last) clear_stream_state();
  endfunction

  // Input channel driver, one compressed word per call, with random gaps.
  // Valid stays up after acceptance until the next call or the drain lowers it.
  task automatic send_word(logic [7:0] b, logic last);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_decode(b, last);
  endtask

  task automatic write_flag(logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    raw_flag = value;
  endtask

  // Waits for every expected word, then for the tail of a long run fill,
  // since a word that causes no result may still keep the block busy.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (recv_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  // Result checker: every accepted word is compared against the oldest expectation.
  always @(posedge clk) begin
    lzrd_tb_pkg::result_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: got byte %h rep %0d err %b last %b", $time,
                 out_ch.out_byte, out_ch.repeat_count, out_ch.distance_error,
                 out_ch.last_of_run);
        fail_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.repeat_count !== want.rep ||
            out_ch.distance_error !== want.err || out_ch.last_of_run !== want.last) begin
          $display("%0t: mismatch: expected byte %h rep %0d err %b last %b,",
                   $time, want.data, want.rep, want.err, want.last);
          $display("%0t:           actual   byte %h rep %0d err %b last %b",
                   $time, out_ch.out_byte, out_ch.repeat_count,
                   out_ch.distance_error, out_ch.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Directed stream. Each row is one compressed word; rows with a typed-in
  // result are checked against it as well as against the predictor.
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         has_fixed;
    logic [7:0] fixed_byte;
    logic       fixed_err;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    // Header 0x00, control word 0x6000: literal, pair, pair, then literals.
    '{8'h00, 1'b0, 0, 8'h00, 1'b0},
    '{8'h60, 1'b0, 0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 0, 8'h00, 1'b0},
    '{8'hff, 1'b0, 1, 8'hff, 1'b0},
    // Copy at distance one over one byte: overlap, length 18.
    '{8'h00, 1'b0, 0, 8'h00, 1'b0},
    '{8'h1f, 1'b0, 0, 8'h00, 1'b0},
    // Run item with the largest count and value 0xa5.
    '{8'h00, 1'b0, 0, 8'h00, 1'b0},
    '{8'h0f, 1'b0, 0, 8'h00, 1'b0},
    '{8'hff, 1'b0, 0, 8'h00, 1'b0},
    '{8'ha5, 1'b0, 0, 8'h00, 1'b0},
    '{8'h00, 1'b1, 1, 8'h00, 1'b0},
    // New stream: a copy at the largest distance has nothing behind it.
    '{8'h02, 1'b0, 0, 8'h00, 1'b0},
    '{8'h80, 1'b0, 0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 0, 8'h00, 1'b0},
    '{8'hff, 1'b0, 0, 8'h00, 1'b0},
    '{8'hf0, 1'b0, 1, 8'h00, 1'b1},
    '{8'h42, 1'b1, 0, 8'h00, 1'b0},
    // Stored stream after the reset flag value.
    '{8'h01, 1'b0, 0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1, 8'h00, 1'b0},
    '{8'hff, 1'b1, 1, 8'hff, 1'b0},
    // Stream cut off inside the header and inside a two-byte item.
    '{8'h07, 1'b1, 0, 8'h00, 1'b0},
    '{8'h07, 1'b0, 0, 8'h00, 1'b0},
    '{8'h80, 1'b0, 0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 0, 8'h00, 1'b0},
    '{8'h00, 1'b1, 0, 8'h00, 1'b0}
  };

  // One compressed stream with random content, cut off if asked; most copy
  // items reach back into the bytes already produced.
  task automatic send_random_stream(int n_items, bit cut_off);
    logic [15:0] ctl;
    logic [7:0] hdr;
    int produced;
    int back_dist;
    int k;
    hdr = 8'($urandom);
    if (hdr == raw_flag) hdr = raw_flag + 8'd1;
    send_word(hdr, 1'b0);
    produced = 0;
    k = 0;
    while (k < n_items) begin
      ctl = 16'($urandom);
      send_word(ctl[15:8], 1'b0);
      send_word(ctl[7:0], 1'b0);
      for (int i = 0; i < 16 && k < n_items; i++, k++) begin
        if (!ctl[15 - i]) begin
          send_word(8'($urandom), cut_off == 0 && k == n_items - 1);
          produced++;
        end else if ($urandom_range(5, 0) == 0) begin
          // Run item; count mostly small to keep the fill short.
          send_word(8'h00, 1'b0);
          send_word({4'h0, ($urandom_range(9, 0) == 0) ? 4'($urandom) : 4'h0}, 1'b0);
          send_word(8'($urandom_range(40, 0)), 1'b0);
          send_word(8'($urandom), cut_off == 0 && k == n_items - 1);
          produced += 16;
        end else begin
          back_dist = ($urandom_range(7, 0) == 0 || produced == 0) ?
                      $urandom_range(4095, 1) :
                      $urandom_range(produced > 4095 ? 4095 : produced, 1);
          send_word(8'(back_dist >> 4), 1'b0);
          send_word({4'(back_dist), 4'($urandom)}, cut_off == 0 && k == n_items - 1);
          produced += 3;
        end
      end
    end
    if (cut_off) send_word(8'h00, 1'b1);
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) send_word(8'($urandom), $urandom_range(3, 0) == 0);
    send_word(8'($urandom), 1'b1);
  endtask

  task automatic run_random_phase(int n_streams);
    for (int s = 0; s < n_streams; s++) begin
      case ($urandom_range(9, 0))
        0: send_noise($urandom_range(8, 1));
        1: begin
          // Stored stream with random payload.
          send_word(raw_flag, 1'b0);
          for (int i = 0; i < 6; i++) send_word(8'($urandom), i == 5);
        end
        2: send_random_stream($urandom_range(12, 2), 1'b1);
        default: send_random_stream($urandom_range(20, 4), 1'b0);
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    raw_flag = 8'd1;
    clear_stream_state();
    for (int i = 0; i < WIN; i++) win_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side.
    foreach (directed_rows[r]) begin
      int before_cnt;
      before_cnt = expected_words.size();
      send_word(directed_rows[r].b, directed_rows[r].last);
      if (directed_rows[r].has_fixed && expected_words.size() > before_cnt &&
          (expected_words[before_cnt].data !== directed_rows[r].fixed_byte ||
           expected_words[before_cnt].err !== directed_rows[r].fixed_err)) begin
        $display("%0t: table row %0d disagrees: expected byte %h err %b, predicted %h %b",
                 $time, r, directed_rows[r].fixed_byte, directed_rows[r].fixed_err,
                 expected_words[before_cnt].data, expected_words[before_cnt].err);
        fail_cnt++;
      end
    end
    drain();

    // Largest flag value; sender idles a quarter of the time, receiver most of it.
    write_flag(8'hff);
    send_idle_pct = 25;
    recv_idle_pct = 74;
    run_random_phase(3);
    drain();

    // Smallest flag value, idling the other way round, plus a long hold-off
    // so that results back up and the input stalls.
    write_flag(8'h00);
    send_idle_pct = 74;
    recv_idle_pct = 25;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      run_random_phase(3);
    join
    drain();

    // A middle flag value with no idling at all.
    write_flag(8'($urandom_range(254, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(3);
    drain();

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
